@@ design/slxfp_pkg.sv @@
// ----------------------------------------------------------------------------
// Frame parser package
// Sizes, result codes, the result record and circular pointer arithmetic
// shared by the frame parser modules.
// ----------------------------------------------------------------------------
package slxfp_pkg;

	localparam int MAX_PAYLOAD  = 32;
	localparam int STORE_DEPTH  = MAX_PAYLOAD + 3;
	localparam int PTR_W        = $clog2(STORE_DEPTH);
	localparam int CNT_W        = $clog2(STORE_DEPTH + 1);
	localparam int LEN_W        = $clog2(MAX_PAYLOAD + 1);
	localparam int TOT_W        = 9;
	localparam int BYTE_W       = 8;
	localparam int STATUS_W     = 2;
	localparam int IDX_W        = 5;
	localparam int FLEN_W       = 6;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hAA;

	typedef enum logic [STATUS_W-1:0] {
		ST_DATA    = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_LEN_ERR = 2'd2,
		ST_CRC_ERR = 2'd3
	} status_t;

	typedef struct packed {
		status_t             status;
		logic [BYTE_W-1:0]   payload_byte;
		logic [IDX_W-1:0]    byte_index;
		logic [FLEN_W-1:0]   frame_length;
	} result_t;

	// Adds an offset of at most one store depth to a store pointer, modulo the depth.
	function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] ptr,
			input logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(ptr) + (CNT_W+1)'(off);
		if (sum >= (CNT_W+1)'(STORE_DEPTH)) begin
			sum = sum - (CNT_W+1)'(STORE_DEPTH);
		end
		return PTR_W'(sum);
	endfunction

endpackage

@@ design/slxfp_ifs.sv @@
// ----------------------------------------------------------------------------
// Frame parser channels
// Valid/ready channels for received bytes and for parse results.
// ----------------------------------------------------------------------------
interface slxfp_rx_if
	import slxfp_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slxfp_res_if
	import slxfp_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [BYTE_W-1:0]   payload_byte;
	logic [IDX_W-1:0]    byte_index;
	logic [FLEN_W-1:0]   frame_length;
	logic                last;

	modport source (output valid, output status, output payload_byte, output byte_index,
		output frame_length, output last, input ready);
	modport sink   (input valid, input status, input payload_byte, input byte_index,
		input frame_length, input last, output ready);
endinterface

@@ design/sync_length_xor_frame_parser.sv @@
// An item is registered in the receive queue before the parse engine takes it. The engine
// takes a new item only in its idle state, once it has applied the framing rule to the
// last one; its pace is set by the single read port of the byte store, most of all on a
// checksum rescan. A four-entry queue takes items meanwhile.
// Reset clears control state and sets the sync byte to 0xAA; store contents are not cleared.
// ----------------------------------------------------------------------------
// Sync/length/XOR frame parser
// Top level: sync byte register, receive queue and parse engine.
// ----------------------------------------------------------------------------
module sync_length_xor_frame_parser
	import slxfp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [BYTE_W-1:0] cfg_wdata,
	slxfp_rx_if.sink          rx,
	slxfp_res_if.source       res
);

	logic [BYTE_W-1:0] sync_q;

	slxfp_rx_if q_if ();

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SYNC_RESET;
		end else if (cfg_we) begin
			sync_q <= cfg_wdata;
		end
	end

	slxfp_rx_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.deq    (q_if.source)
	);

	slxfp_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.sync_byte (sync_q),
		.deq       (q_if.sink),
		.res       (res)
	);

endmodule

@@ design/slxfp_rx_queue.sv @@
// ----------------------------------------------------------------------------
// Frame parser receive queue
// Accepts received bytes and holds a few of them while the parse engine works.
// ----------------------------------------------------------------------------
module slxfp_rx_queue
	import slxfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	slxfp_rx_if.sink   rx,
	slxfp_rx_if.source deq
);

	logic [BYTE_W-1:0] entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign rx.ready    = (count_q < QCNT_W'(QUEUE_DEPTH));
	assign deq.valid   = (count_q != '0);
	assign deq.rx_byte = entry_q[rd_ptr_q];
	assign push        = rx.valid && rx.ready;
	assign pop         = deq.valid && deq.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

@@ design/slxfp_engine.sv @@
// ----------------------------------------------------------------------------
// Frame parser engine
// Appends each item to the circular byte store and applies the framing rule
// through one memory read port until more data is needed.
// ----------------------------------------------------------------------------
module slxfp_engine
	import slxfp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [BYTE_W-1:0] sync_byte,
	slxfp_rx_if.sink          deq,
	slxfp_res_if.source       res
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_HEAD = 7'b0000010,
		S_HCHK = 7'b0000100,
		S_LEN  = 7'b0001000,
		S_SUM  = 7'b0010000,
		S_EMIT = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	logic [BYTE_W-1:0] store_q [STORE_DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	state_t            state_q, state_d;
	logic [PTR_W-1:0]  head_q;
	logic [CNT_W-1:0]  fill_q;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [LEN_W-1:0]  idx_q, idx_d;
	logic [BYTE_W-1:0] xsum_q, xsum_d;
	logic              held_v_q;
	result_t           held_q;
	logic              out_v_q;
	result_t           out_q;
	logic              out_last_q;

	logic [PTR_W-1:0]  rd_addr;
	logic              wr_en;
	logic [CNT_W-1:0]  drop_n;
	logic              fill_inc;
	logic              emit_req;
	result_t           emit_res;
	logic              flush;
	logic              out_free;
	logic              stall;
	logic              push_out;

	assign out_free = !out_v_q || res.ready;
	assign stall    = (emit_req || flush) && held_v_q && !out_free;
	assign push_out = (emit_req || flush) && held_v_q && !stall;

	always_comb begin
		state_d  = state_q;
		len_d    = len_q;
		idx_d    = idx_q;
		xsum_d   = xsum_q;
		rd_addr  = head_q;
		wr_en    = 1'b0;
		fill_inc = 1'b0;
		drop_n   = '0;
		emit_req = 1'b0;
		emit_res = '0;
		flush    = 1'b0;
		deq.ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				deq.ready = 1'b1;
				if (deq.valid) begin
					if (fill_q < CNT_W'(STORE_DEPTH)) begin
						wr_en    = 1'b1;
						fill_inc = 1'b1;
					end
					state_d = S_HEAD;
				end
			end
			S_HEAD: begin
				if (fill_q == '0) begin
					state_d = S_DONE;
				end else begin
					state_d = S_HCHK;
				end
			end
			S_HCHK: begin
				if (rd_data_q != sync_byte) begin
					drop_n  = CNT_W'(1);
					state_d = S_HEAD;
				end else if (fill_q < CNT_W'(2)) begin
					state_d = S_DONE;
				end else begin
					rd_addr = ptr_add(head_q, CNT_W'(1));
					state_d = S_LEN;
				end
			end
			S_LEN: begin
				if (rd_data_q > BYTE_W'(MAX_PAYLOAD)) begin
					drop_n          = CNT_W'(1);
					emit_req        = 1'b1;
					emit_res.status = ST_LEN_ERR;
					state_d         = S_HEAD;
				end else if (TOT_W'(fill_q) < TOT_W'(rd_data_q) + TOT_W'(3)) begin
					state_d = S_DONE;
				end else begin
					len_d   = LEN_W'(rd_data_q);
					idx_d   = '0;
					xsum_d  = '0;
					rd_addr = ptr_add(head_q, CNT_W'(2));
					state_d = S_SUM;
				end
			end
			S_SUM: begin
				if (idx_q == len_q) begin
					if (rd_data_q != xsum_q) begin
						drop_n          = CNT_W'(1);
						emit_req        = 1'b1;
						emit_res.status = ST_CRC_ERR;
						state_d         = S_HEAD;
					end else if (len_q == '0) begin
						drop_n          = CNT_W'(3);
						emit_req        = 1'b1;
						emit_res.status = ST_EMPTY;
						state_d         = S_HEAD;
					end else begin
						idx_d   = '0;
						rd_addr = ptr_add(head_q, CNT_W'(2));
						state_d = S_EMIT;
					end
				end else begin
					xsum_d  = xsum_q ^ rd_data_q;
					idx_d   = idx_q + LEN_W'(1);
					rd_addr = ptr_add(head_q, CNT_W'(idx_q) + CNT_W'(3));
				end
			end
			S_EMIT: begin
				emit_req              = 1'b1;
				emit_res.status       = ST_DATA;
				emit_res.payload_byte = rd_data_q;
				emit_res.byte_index   = IDX_W'(idx_q);
				emit_res.frame_length = FLEN_W'(len_q);
				if (idx_q == len_q - LEN_W'(1)) begin
					drop_n  = CNT_W'(len_q) + CNT_W'(3);
					state_d = S_HEAD;
				end else begin
					idx_d   = idx_q + LEN_W'(1);
					rd_addr = ptr_add(head_q, CNT_W'(idx_q) + CNT_W'(3));
				end
			end
			S_DONE: begin
				flush   = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[ptr_add(head_q, fill_q)] <= deq.rx_byte;
		end
		if (!stall) begin
			rd_data_q <= store_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			fill_q     <= '0;
			len_q      <= '0;
			idx_q      <= '0;
			xsum_q     <= '0;
			held_v_q   <= 1'b0;
			held_q     <= '0;
			out_v_q    <= 1'b0;
			out_q      <= '0;
			out_last_q <= 1'b0;
		end else begin
			if (!stall) begin
				state_q <= state_d;
				head_q  <= ptr_add(head_q, drop_n);
				fill_q  <= fill_q + CNT_W'(fill_inc) - drop_n;
				len_q   <= len_d;
				idx_q   <= idx_d;
				xsum_q  <= xsum_d;
				if (emit_req) begin
					held_v_q <= 1'b1;
					held_q   <= emit_res;
				end else if (flush) begin
					held_v_q <= 1'b0;
				end
			end
			if (push_out) begin
				out_v_q    <= 1'b1;
				out_q      <= held_q;
				out_last_q <= flush;
			end else if (res.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign res.valid        = out_v_q;
	assign res.status       = out_q.status;
	assign res.payload_byte = out_q.payload_byte;
	assign res.byte_index   = out_q.byte_index;
	assign res.frame_length = out_q.frame_length;
	assign res.last         = out_last_q;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame parser testbench
// Feeds received bytes into the sync/length/XOR frame parser and checks each result
// against a local parser with its own byte store and sync byte, or against a result
// typed in its table. A short table of hand-picked bytes comes first, then random frames
// (good, corrupted checksum, oversized length and line noise) under four sync byte
// settings, with random idling on both channels and a long result back-pressure stretch.
// ----------------------------------------------------------------------------
module testbench;
	import slxfp_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int SETTLE_TIME  = 1500;
	localparam int PHASE_ITEMS  = 18;
	localparam int LONG_STALL   = 400;

	typedef struct packed {
		status_t             status;
		logic [BYTE_W-1:0]   payload_byte;
		logic [IDX_W-1:0]    byte_index;
		logic [FLEN_W-1:0]   frame_length;
		logic                last;
	} parse_result_t;

	typedef struct {
		logic [BYTE_W-1:0] value;
		bit                typed;
		status_t           typed_status;
	} stim_row_t;

	typedef enum {FR_GOOD, FR_BAD_SUM, FR_BAD_LEN, FR_NOISE} frame_kind_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [BYTE_W-1:0] cfg_wdata;

	slxfp_rx_if  rx_ch ();
	slxfp_res_if res_ch ();

	sync_length_xor_frame_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rx        (rx_ch),
		.res       (res_ch)
	);

	logic [BYTE_W-1:0] held_bytes [$];
	logic [BYTE_W-1:0] sync_value;
	parse_result_t     fresh_results [$];
	parse_result_t     pending_results [$];

	int  fail_count;
	int  mismatch_count;
	int  items_sent;
	int  results_checked;
	int  status_seen [4];
	int  cycle_count;
	bit  quiet_mode;
	bit  long_stall_req;
	int  hold_left;
	int  idle_left;
	int  calm_left;

	// The rows carry a typed result only where one error or empty-frame result is obvious.
	stim_row_t directed_rows [21] = '{
		'{8'h00, 1'b0, ST_DATA},
		'{8'hFF, 1'b0, ST_DATA},
		'{8'hAA, 1'b0, ST_DATA},
		'{8'h21, 1'b1, ST_LEN_ERR},
		'{8'hAA, 1'b0, ST_DATA},
		'{8'h00, 1'b0, ST_DATA},
		'{8'h00, 1'b1, ST_EMPTY},
		'{8'hAA, 1'b0, ST_DATA},
		'{8'h01, 1'b0, ST_DATA},
		'{8'h55, 1'b0, ST_DATA},
		'{8'h00, 1'b1, ST_CRC_ERR},
		'{8'hAA, 1'b0, ST_DATA},
		'{8'h01, 1'b0, ST_DATA},
		'{8'hFF, 1'b0, ST_DATA},
		'{8'hFF, 1'b0, ST_DATA},
		'{8'hAA, 1'b0, ST_DATA},
		'{8'h03, 1'b0, ST_DATA},
		'{8'hAA, 1'b0, ST_DATA},
		'{8'h00, 1'b0, ST_DATA},
		'{8'h00, 1'b0, ST_DATA},
		'{8'h11, 1'b0, ST_DATA}
	};

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	function automatic void add_result(input status_t st, input logic [BYTE_W-1:0] data,
			input int index, input int flen);
		parse_result_t r;
		r.status       = st;
		r.payload_byte = data;
		r.byte_index   = IDX_W'(index);
		r.frame_length = FLEN_W'(flen);
		r.last         = 1'b0;
		fresh_results.push_back(r);
	endfunction

	// Appends one byte to the held store and applies the framing rule until more data is needed.
	function automatic void parse_byte(input logic [BYTE_W-1:0] value);
		int len;
		logic [BYTE_W-1:0] x;
		fresh_results.delete();
		if (held_bytes.size() < STORE_DEPTH) begin
			held_bytes.push_back(value);
		end
		while (held_bytes.size() > 0) begin
			if (held_bytes[0] != sync_value) begin
				void'(held_bytes.pop_front());
				continue;
			end
			if (held_bytes.size() < 2) begin
				break;
			end
			len = int'(held_bytes[1]);
			if (len > MAX_PAYLOAD) begin
				void'(held_bytes.pop_front());
				add_result(ST_LEN_ERR, '0, 0, 0);
				continue;
			end
			if (held_bytes.size() < len + 3) begin
				break;
			end
			x = '0;
			for (int i = 0; i < len; i++) begin
				x ^= held_bytes[2 + i];
			end
			if (x != held_bytes[2 + len]) begin
				void'(held_bytes.pop_front());
				add_result(ST_CRC_ERR, '0, 0, 0);
				continue;
			end
			if (len == 0) begin
				add_result(ST_EMPTY, '0, 0, 0);
			end else begin
				for (int i = 0; i < len; i++) begin
					add_result(ST_DATA, held_bytes[2 + i], i, len);
				end
			end
			repeat (len + 3) void'(held_bytes.pop_front());
		end
		if (fresh_results.size() > 0) begin
			fresh_results[fresh_results.size() - 1].last = 1'b1;
		end
	endfunction

	task automatic push_byte(input logic [BYTE_W-1:0] value, input bit typed = 1'b0,
			input status_t typed_status = ST_DATA);
		parse_result_t r;
		if (!quiet_mode && $urandom_range(0, 4) == 0) begin
			rx_ch.valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		rx_ch.valid   = 1'b1;
		rx_ch.rx_byte = value;
		do begin
			@(posedge clk);
		end while (!(rx_ch.valid && rx_ch.ready));
		parse_byte(value);
		if (typed) begin
			r = '{typed_status, 8'h00, 5'd0, 6'd0, 1'b1};
			pending_results.push_back(r);
		end else begin
			foreach (fresh_results[i]) pending_results.push_back(fresh_results[i]);
		end
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame(input frame_kind_t kind, input int len);
		logic [BYTE_W-1:0] sum;
		logic [BYTE_W-1:0] b;
		case (kind)
			FR_NOISE: begin
				repeat ($urandom_range(1, 4)) push_byte(BYTE_W'($urandom_range(0, 255)));
			end
			FR_BAD_LEN: begin
				push_byte(sync_value);
				push_byte(BYTE_W'($urandom_range(MAX_PAYLOAD + 1, 255)));
				repeat ($urandom_range(0, 2)) push_byte(BYTE_W'($urandom_range(0, 255)));
			end
			default: begin
				push_byte(sync_value);
				push_byte(BYTE_W'(len));
				sum = '0;
				for (int i = 0; i < len; i++) begin
					b = ($urandom_range(0, 3) == 0) ? sync_value : BYTE_W'($urandom_range(0, 255));
					sum ^= b;
					push_byte(b);
				end
				if (kind == FR_BAD_SUM) begin
					sum ^= BYTE_W'($urandom_range(1, 255));
				end
				push_byte(sum);
			end
		endcase
	endtask

	task automatic settle_and_configure(input logic [BYTE_W-1:0] new_sync);
		rx_ch.valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_TIME) @(posedge clk);
		@(negedge clk);
		cfg_we     = 1'b1;
		cfg_wdata  = new_sync;
		sync_value = new_sync;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	always @(posedge clk) begin
		parse_result_t got;
		parse_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = '{status_t'(res_ch.status), res_ch.payload_byte, res_ch.byte_index,
				res_ch.frame_length, res_ch.last};
			results_checked++;
			status_seen[got.status]++;
			if (pending_results.size() == 0) begin
				fail_count++;
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("Unexpected result: status %0d byte %h index %0d length %0d last %b",
						got.status, got.payload_byte, got.byte_index, got.frame_length, got.last);
				end
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.payload_byte !== want.payload_byte ||
						got.byte_index !== want.byte_index ||
						got.frame_length !== want.frame_length || got.last !== want.last) begin
					fail_count++;
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("Mismatch: expected status %0d byte %h index %0d length %0d last %b",
							want.status, want.payload_byte, want.byte_index, want.frame_length,
							want.last);
						$display("          actual   status %0d byte %h index %0d length %0d last %b",
							got.status, got.payload_byte, got.byte_index, got.frame_length,
							got.last);
					end
				end
			end
		end
	end

	initial begin
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_stall_req && hold_left == 0) begin
				hold_left      = LONG_STALL;
				long_stall_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready = 1'b0;
			end else if (quiet_mode) begin
				res_ch.ready = 1'b1;
			end else if (idle_left > 0) begin
				idle_left--;
				res_ch.ready = 1'b0;
			end else if (calm_left > 0) begin
				calm_left--;
				res_ch.ready = 1'b1;
			end else if ($urandom_range(0, 4) == 0) begin
				idle_left    = $urandom_range(1, 6) - 1;
				res_ch.ready = 1'b0;
				if ($urandom_range(0, 2) == 0) begin
					calm_left = $urandom_range(20, 60);
				end
			end else begin
				res_ch.ready = 1'b1;
			end
		end
	end

	initial begin
		logic [BYTE_W-1:0] phase_sync [4];
		int phase_start;
		int roll;
		int len;
		frame_kind_t kind;

		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = '0;
		sync_value    = SYNC_RESET;
		held_bytes.delete();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			push_byte(directed_rows[i].value, directed_rows[i].typed,
				directed_rows[i].typed_status);
		end

		phase_sync = '{8'h00, 8'hFF, BYTE_W'($urandom_range(0, 255)), 8'hAA};
		for (int p = 0; p < 4; p++) begin
			settle_and_configure(phase_sync[p]);
			if (p == 1) begin
				long_stall_req = 1'b1;
			end
			if (p == 3) begin
				quiet_mode = 1'b1;
			end
			phase_start = items_sent;
			if (p == 0) begin
				send_frame(FR_GOOD, MAX_PAYLOAD);
			end
			while (items_sent - phase_start < PHASE_ITEMS) begin
				roll = $urandom_range(0, 99);
				if (roll < 60) kind = FR_GOOD;
				else if (roll < 75) kind = FR_BAD_SUM;
				else if (roll < 85) kind = FR_BAD_LEN;
				else kind = FR_NOISE;
				roll = $urandom_range(0, 99);
				if (roll < 70) len = $urandom_range(0, 4);
				else if (roll < 95) len = $urandom_range(5, MAX_PAYLOAD - 1);
				else len = MAX_PAYLOAD;
				send_frame(kind, len);
			end
		end

		rx_ch.valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_TIME) @(posedge clk);

		$display("Sent %0d bytes under five sync settings, checked %0d results.",
			items_sent, results_checked);
		$display("Results: %0d payload, %0d empty frame, %0d length error, %0d checksum error.",
			status_seen[ST_DATA], status_seen[ST_EMPTY], status_seen[ST_LEN_ERR],
			status_seen[ST_CRC_ERR]);
		if (fail_count == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
